// ===== hw/rtl/vam_pkg.sv =====
// Shared widths, constants, types and the arctangent table for the
// vector angle and magnitude unit. No dependencies.
`default_nettype none

package vam_pkg;

    localparam int DATA_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_BITS    = 8;

    localparam int TOL_W   = 8;
    localparam int ANGLE_W = 15;
    localparam int MAG_W   = 16;
    localparam int QUAD_W  = 13;

    // CORDIC x/y: |component| * 2^GUARD_BITS grown by the CORDIC gain, plus sign
    localparam int CORD_W = DATA_WIDTH + GUARD_BITS + 4;
    // angle accumulator in 2^-16 degree
    localparam int Z_W    = 25;

    localparam int LO_W   = 15;
    localparam int HI_W   = CORD_W - 1 - LO_W;
    localparam int GAIN_W = 30;
    localparam int PHI_W  = HI_W + GAIN_W;
    localparam int PLO_W  = LO_W + GAIN_W;
    localparam int SUM_W  = PHI_W + 1;
    localparam int RND_SH = 23;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);

    localparam logic [QUAD_W-1:0]  QUAD_MAX = QUAD_W'(5760);
    localparam logic [ANGLE_W-1:0] ANG_0    = ANGLE_W'(0);
    localparam logic [ANGLE_W-1:0] ANG_90   = ANGLE_W'(5760);
    localparam logic [ANGLE_W-1:0] ANG_180  = ANGLE_W'(11520);
    localparam logic [ANGLE_W-1:0] ANG_270  = ANGLE_W'(17280);
    localparam logic [ANGLE_W-1:0] ANG_360  = ANGLE_W'(23040);

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_pos;
        logic x_neg;
        logic y_pos;
    } axis_flags_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] cy;
        logic signed [Z_W-1:0]    z;
        axis_flags_t              flags;
    } cordic_word_t;

    // round(atan(2^-i) in degrees * 2^16)
    function automatic logic [Z_W-1:0] atan_entry(input int idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            0:       v = Z_W'(2949120);
            1:       v = Z_W'(1740967);
            2:       v = Z_W'(919879);
            3:       v = Z_W'(466945);
            4:       v = Z_W'(234379);
            5:       v = Z_W'(117304);
            6:       v = Z_W'(58666);
            7:       v = Z_W'(29335);
            8:       v = Z_W'(14668);
            9:       v = Z_W'(7334);
            10:      v = Z_W'(3667);
            11:      v = Z_W'(1833);
            12:      v = Z_W'(917);
            13:      v = Z_W'(458);
            14:      v = Z_W'(229);
            15:      v = Z_W'(115);
            16:      v = Z_W'(57);
            17:      v = Z_W'(29);
            18:      v = Z_W'(14);
            19:      v = Z_W'(7);
            20:      v = Z_W'(4);
            21:      v = Z_W'(2);
            22:      v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vec2_angle_and_magnitude_unit.sv =====
// Top level of the vector angle and magnitude unit: a fully unrolled,
// gain-compensated vectoring CORDIC. Depends on vam_pkg.
`default_nettype none

// Takes a signed vector (x_component, y_component) and returns its polar
// angle in 1/64 degree (0 up to just below 360 degrees) and its rounded
// Euclidean length. Both components are folded into the first quadrant by
// absolute value, scaled by 2^8 and rotated toward the x axis by one CORDIC
// stage per pipeline register (CORDIC_STAGES stages). The accumulated
// first-quadrant angle is then placed in its quadrant as atan2 does, and the
// final x value is multiplied by the inverse CORDIC gain. A component whose
// magnitude is at most zero_tolerance counts as zero: the angle then snaps to
// 0, 90, 180 or 270 degrees (0 at the origin) and on_axis is set; the
// magnitude always comes from the true components. Rate: one word per clock,
// sustained while out_stall is low. Registers in order: one input register,
// one register per CORDIC stage, then angle rounding and operand split, the
// inverse-gain multiply and quadrant placement, and the rounding sum.
// Each register stage holds its word until the next stage is empty or
// moving, so a stall on the output backs up stage by stage and bubbles are
// squeezed out. Write zero_tolerance through cfg_data only while the unit
// is empty; cfg_ready is always high.
module vec2_angle_and_magnitude_unit
    import vam_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [TOL_W-1:0]             cfg_data,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [DATA_WIDTH-1:0] x_component,
    input  wire logic signed [DATA_WIDTH-1:0] y_component,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ANGLE_W-1:0]                angle_deg,
    output logic [MAG_W-1:0]                  magnitude,
    output logic                              on_axis
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage registers and per-stage valid bits.
    // s_reg[0] is the input register, s_reg[k+1] holds the word after
    // CORDIC stage k. Then p1 (round/split), p2 (multiply/quadrant), out.
    // ------------------------------------------------------------------
    cordic_word_t s_reg  [0:CORDIC_STAGES];
    logic         sv_reg [0:CORDIC_STAGES];
    logic         s_en   [0:CORDIC_STAGES];

    logic [QUAD_W-1:0] p1_quad_reg,  p1_quad_next;
    logic [HI_W-1:0]   p1_hi_reg,    p1_hi_next;
    logic [LO_W-1:0]   p1_lo_reg,    p1_lo_next;
    axis_flags_t       p1_flags_reg;
    logic              p1_valid_reg;
    logic              p1_en;

    logic [PHI_W-1:0]   p2_phi_reg,   p2_phi_next;
    logic [PLO_W-1:0]   p2_plo_reg,   p2_plo_next;
    logic [ANGLE_W-1:0] p2_angle_reg, p2_angle_next;
    logic               p2_axis_reg,  p2_axis_next;
    logic               p2_valid_reg;
    logic               p2_en;

    logic [ANGLE_W-1:0] angle_reg;
    logic [MAG_W-1:0]   mag_reg,      mag_next;
    logic               axis_reg;
    logic               out_valid_reg;
    logic               out_en;

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        out_en = !out_valid_reg || !out_stall;
        p2_en  = !p2_valid_reg || out_en;
        p1_en  = !p1_valid_reg || p2_en;
        s_en[CORDIC_STAGES] = !sv_reg[CORDIC_STAGES] || p1_en;
        for (int k = CORDIC_STAGES - 1; k >= 0; k--)
        begin
            s_en[k] = !sv_reg[k] || s_en[k+1];
        end
    end

    assign in_stall = !s_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_en[0])
            begin
                sv_reg[0] <= in_valid;
            end
            for (int k = 1; k <= CORDIC_STAGES; k++)
            begin
                if (s_en[k])
                begin
                    sv_reg[k] <= sv_reg[k-1];
                end
            end
            if (p1_en)
            begin
                p1_valid_reg <= sv_reg[CORDIC_STAGES];
            end
            if (p2_en)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: fold into the first quadrant, test against tolerance.
    // ------------------------------------------------------------------
    logic signed [DATA_WIDTH:0] x_ext;
    logic signed [DATA_WIDTH:0] y_ext;
    logic [DATA_WIDTH:0]        x_abs;
    logic [DATA_WIDTH:0]        y_abs;
    logic [DATA_WIDTH:0]        tol_ext;
    cordic_word_t               s0_next;

    always_comb
    begin
        x_ext   = {x_component[DATA_WIDTH-1], x_component};
        y_ext   = {y_component[DATA_WIDTH-1], y_component};
        x_abs   = x_ext[DATA_WIDTH] ? unsigned'(-x_ext) : unsigned'(x_ext);
        y_abs   = y_ext[DATA_WIDTH] ? unsigned'(-y_ext) : unsigned'(y_ext);
        tol_ext = {{(DATA_WIDTH + 1 - TOL_W){1'b0}}, tol_reg};

        s0_next.cx = signed'({{(CORD_W - DATA_WIDTH - 1 - GUARD_BITS){1'b0}},
                              x_abs, {GUARD_BITS{1'b0}}});
        s0_next.cy = signed'({{(CORD_W - DATA_WIDTH - 1 - GUARD_BITS){1'b0}},
                              y_abs, {GUARD_BITS{1'b0}}});
        s0_next.z  = '0;
        s0_next.flags.x_zero = (x_abs <= tol_ext);
        s0_next.flags.y_zero = (y_abs <= tol_ext);
        s0_next.flags.x_pos  = !x_component[DATA_WIDTH-1] && (x_component != '0);
        s0_next.flags.x_neg  = x_component[DATA_WIDTH-1];
        s0_next.flags.y_pos  = !y_component[DATA_WIDTH-1] && (y_component != '0);
    end

    always_ff @(posedge clk)
    begin
        if (s_en[0])
        begin
            s_reg[0] <= s0_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC stages: rotate toward the x axis, one micro-rotation each.
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_cordic
            logic signed [CORD_W-1:0] dx;
            logic signed [CORD_W-1:0] dy;
            logic signed [Z_W-1:0]    step;
            cordic_word_t             stage_next;

            assign dx   = $signed(s_reg[gi].cy) >>> gi;
            assign dy   = $signed(s_reg[gi].cx) >>> gi;
            assign step = signed'(atan_entry(gi));

            always_comb
            begin
                stage_next = s_reg[gi];
                if (!s_reg[gi].cy[CORD_W-1])
                begin
                    stage_next.cx = s_reg[gi].cx + dx;
                    stage_next.cy = s_reg[gi].cy - dy;
                    stage_next.z  = s_reg[gi].z + step;
                end
                else
                begin
                    stage_next.cx = s_reg[gi].cx - dx;
                    stage_next.cy = s_reg[gi].cy + dy;
                    stage_next.z  = s_reg[gi].z - step;
                end
            end

            always_ff @(posedge clk)
            begin
                if (s_en[gi+1])
                begin
                    s_reg[gi+1] <= stage_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // P1: round the angle to 1/64 degree, clamp; split x for the multiply.
    // ------------------------------------------------------------------
    logic [Z_W-1:0]     z_clamp;
    logic [Z_W-1:0]     z_round;
    logic [Z_W-11:0]    quad_wide;
    logic [CORD_W-2:0]  x_final;

    always_comb
    begin
        z_clamp   = s_reg[CORDIC_STAGES].z[Z_W-1] ? '0
                                                  : unsigned'(s_reg[CORDIC_STAGES].z);
        z_round   = z_clamp + Z_W'(512);
        quad_wide = z_round[Z_W-1:10];
        if (quad_wide > (Z_W - 10)'(QUAD_MAX))
        begin
            p1_quad_next = QUAD_MAX;
        end
        else
        begin
            p1_quad_next = quad_wide[QUAD_W-1:0];
        end

        x_final    = s_reg[CORDIC_STAGES].cx[CORD_W-1] ? '0
                                                       : s_reg[CORDIC_STAGES].cx[CORD_W-2:0];
        p1_hi_next = x_final[CORD_W-2:LO_W];
        p1_lo_next = x_final[LO_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (p1_en)
        begin
            p1_quad_reg  <= p1_quad_next;
            p1_hi_reg    <= p1_hi_next;
            p1_lo_reg    <= p1_lo_next;
            p1_flags_reg <= s_reg[CORDIC_STAGES].flags;
        end
    end

    // ------------------------------------------------------------------
    // P2: inverse-gain partial products; place the angle in its quadrant.
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] quad_ext;
    logic [ANGLE_W-1:0] angle_raw;

    always_comb
    begin
        p2_phi_next = PHI_W'(p1_hi_reg) * PHI_W'(INV_GAIN_Q30);
        p2_plo_next = PLO_W'(p1_lo_reg) * PLO_W'(INV_GAIN_Q30);

        quad_ext  = ANGLE_W'(p1_quad_reg);
        angle_raw = ANG_0;
        p2_axis_next = 1'b1;
        priority if (p1_flags_reg.x_zero && p1_flags_reg.y_zero)
        begin
            p2_angle_next = ANG_0;
        end
        else if (p1_flags_reg.x_zero)
        begin
            p2_angle_next = p1_flags_reg.y_pos ? ANG_90 : ANG_270;
        end
        else if (p1_flags_reg.y_zero)
        begin
            p2_angle_next = p1_flags_reg.x_pos ? ANG_0 : ANG_180;
        end
        else
        begin
            p2_axis_next = 1'b0;
            priority if (p1_flags_reg.x_pos && p1_flags_reg.y_pos)
            begin
                angle_raw = quad_ext;
            end
            else if (p1_flags_reg.x_neg && p1_flags_reg.y_pos)
            begin
                angle_raw = ANG_180 - quad_ext;
            end
            else if (p1_flags_reg.x_neg)
            begin
                angle_raw = ANG_180 + quad_ext;
            end
            else
            begin
                angle_raw = ANG_360 - quad_ext;
            end
            // wrap a full turn back to zero
            p2_angle_next = (angle_raw >= ANG_360) ? ANG_0 : angle_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_en)
        begin
            p2_phi_reg   <= p2_phi_next;
            p2_plo_reg   <= p2_plo_next;
            p2_angle_reg <= p2_angle_next;
            p2_axis_reg  <= p2_axis_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sum partial products, round half up, saturate.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] mag_sum;
    logic [SUM_W-1:0] mag_rounded;

    always_comb
    begin
        mag_sum     = SUM_W'(p2_phi_reg) + SUM_W'(p2_plo_reg[PLO_W-1:LO_W]);
        mag_rounded = mag_sum + (SUM_W'(1) << (RND_SH - 1));
        if (mag_rounded[SUM_W-1:RND_SH] > (SUM_W - RND_SH)'({MAG_W{1'b1}}))
        begin
            mag_next = {MAG_W{1'b1}};
        end
        else
        begin
            mag_next = mag_rounded[RND_SH+MAG_W-1:RND_SH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            angle_reg <= p2_angle_reg;
            mag_reg   <= mag_next;
            axis_reg  <= p2_axis_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_deg = angle_reg;
    assign magnitude = mag_reg;
    assign on_axis   = axis_reg;

endmodule

`default_nettype wire

// ===== test/vec2_angle_and_magnitude_unit_test.sv =====
// Self-checking testbench for vec2_angle_and_magnitude_unit: random and
// directed vectors, stalls on both sides, and checks of angle, length and axis flag.
// Depends on vam_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module vec2_angle_and_magnitude_unit_test;
    import vam_pkg::*;

    // Pipeline depth plus margin; used when waiting for the unit to empty.
    localparam int LATENCY = CORDIC_STAGES + 4 + 4;

    // atan(2^-i) in degrees, scaled by 2^16 and rounded.
    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };
    localparam longint INV_GAIN = 64'd652032874;
    localparam longint MAG_SAT  = 64'd65535;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
    } vec_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [MAG_W-1:0]   mag;
        logic               axis;
    } polar_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [TOL_W-1:0]             cfg_data = '0;

    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic signed [DATA_WIDTH-1:0] x_component = '0;
    logic signed [DATA_WIDTH-1:0] y_component = '0;

    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ANGLE_W-1:0]           angle_deg;
    logic [MAG_W-1:0]             magnitude;
    logic                         on_axis;

    // Vectors waiting to be sent, and polar words waiting to come back.
    vec_t   vec_pending [$];
    polar_t polar_due   [$];

    // Tolerance the unit currently holds, mirrored on every write.
    logic [TOL_W-1:0] tol_now = '0;

    // Idle odds in percent for each side; changed by the stimulus between chunks.
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int send_gap     = 0;
    int stall_left   = 0;

    int words_sent     = 0;
    int words_checked  = 0;
    int axis_seen      = 0;
    int settings_used  = 1;
    int mismatches     = 0;

    vec2_angle_and_magnitude_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_component (x_component),
        .y_component (y_component),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .angle_deg   (angle_deg),
        .magnitude   (magnitude),
        .on_axis     (on_axis)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected angle, length and axis flag of one vector under tolerance tol.
    // Fold into quadrant I, rotate toward the x axis, then unfold the angle.
    function automatic polar_t predict_polar(input logic signed [DATA_WIDTH-1:0] xc,
                                             input logic signed [DATA_WIDTH-1:0] yc,
                                             input logic [TOL_W-1:0] tol);
        longint sx, sy, ax, ay, cx, cy, z, dx, dy;
        longint quad, ux, hi, lo, total, mag, ang;
        bit     xz, yz, axis;
        int     i;
        polar_t r;
        sx = xc;
        sy = yc;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        cx = ax * (64'sd1 <<< GUARD_BITS);
        cy = ay * (64'sd1 <<< GUARD_BITS);
        z  = 0;
        for (i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            // arithmetic shift of a signed longint rounds toward minus infinity
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + ATAN_Q16[i];
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - ATAN_Q16[i];
            end
        end
        if (z < 0)
            z = 0;
        quad = (z + 512) >>> 10;
        if (quad > 5760)
            quad = 5760;

        // inverse gain in Q30, split so the low product keeps only its upper bits
        ux    = (cx < 0) ? 0 : cx;
        hi    = ux >>> 15;
        lo    = ux & 64'h7FFF;
        total = hi * INV_GAIN + ((lo * INV_GAIN) >>> 15);
        mag   = (total + (64'sd1 <<< 22)) >>> 23;
        if (mag > MAG_SAT)
            mag = MAG_SAT;

        xz   = ax <= longint'(tol);
        yz   = ay <= longint'(tol);
        axis = 1'b1;
        if (xz && yz)
            ang = longint'(ANG_0);
        else if (xz)
            ang = (sy > 0) ? longint'(ANG_90) : longint'(ANG_270);
        else if (yz)
            ang = (sx > 0) ? longint'(ANG_0) : longint'(ANG_180);
        else
        begin
            axis = 1'b0;
            if (sx > 0 && sy > 0)
                ang = quad;
            else if (sx < 0 && sy > 0)
                ang = longint'(ANG_180) - quad;
            else if (sx < 0)
                ang = longint'(ANG_180) + quad;
            else
                ang = longint'(ANG_360) - quad;
            // a fourth-quadrant angle of a full turn wraps to zero
            if (ang >= longint'(ANG_360))
                ang = 0;
        end
        r.angle = ang[ANGLE_W-1:0];
        r.mag   = mag[MAG_W-1:0];
        r.axis  = axis;
        return r;
    endfunction

    // Idle length from three ranges: short ones most often, long pauses rarely.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One random component: full range, small values, the extremes, or values
    // right at the zero tolerance so the axis decisions flip both ways.
    function automatic logic signed [DATA_WIDTH-1:0] pick_component(input int tol);
        int r, m;
        r = $urandom_range(0, 99);
        if (r < 35)
            return DATA_WIDTH'($urandom);
        if (r < 55)
            return DATA_WIDTH'(int'($urandom_range(0, 600)) - 300);
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0:       return DATA_WIDTH'(-32768);
                1:       return DATA_WIDTH'(32767);
                2:       return DATA_WIDTH'(-32767);
                default: return DATA_WIDTH'(0);
            endcase
        end
        if (r < 85)
        begin
            m = tol + int'($urandom_range(0, 2)) - 1;
            if (m < 0)
                m = 0;
            return DATA_WIDTH'($urandom_range(0, 1) ? -m : m);
        end
        return DATA_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    // Driver: hold a stalled word, otherwise count down the gap, then send the
    // next pending vector. Predict each word at the edge that accepts it.
    always @(posedge clk)
    begin
        vec_t v;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                polar_due.push_back(predict_polar(x_component, y_component, tol_now));
                words_sent++;
                send_gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
            end
            if (in_valid && in_stall)
            begin
                // hold the word and its payload
            end
            else if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (vec_pending.size() != 0)
            begin
                v = vec_pending.pop_front();
                x_component <= v.x;
                y_component <= v.y;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction,
    // then decide whether to stall the next cycle.
    always @(posedge clk)
    begin
        polar_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (polar_due.size() == 0)
                begin
                    $error("unexpected result word: angle_deg %0d magnitude %0d on_axis %0d",
                           angle_deg, magnitude, on_axis);
                    mismatches++;
                end
                else
                begin
                    want = polar_due.pop_front();
                    if (angle_deg !== want.angle)
                    begin
                        $error("angle_deg: expected %0d, got %0d", want.angle, angle_deg);
                        mismatches++;
                    end
                    if (magnitude !== want.mag)
                    begin
                        $error("magnitude: expected %0d, got %0d", want.mag, magnitude);
                        mismatches++;
                    end
                    if (on_axis !== want.axis)
                    begin
                        $error("on_axis: expected %0d, got %0d", want.axis, on_axis);
                        mismatches++;
                    end
                    words_checked++;
                    if (want.axis)
                        axis_seen++;
                end
            end
            if (stall_left != 0)
                stall_left--;
            else if ($urandom_range(0, 99) < out_idle_pct)
                stall_left = pick_gap();
            out_stall <= (stall_left != 0);
        end
    end

    task automatic queue_vec(input int xv, input int yv);
        vec_t v;
        v.x = DATA_WIDTH'(xv);
        v.y = DATA_WIDTH'(yv);
        vec_pending.push_back(v);
    endtask

    // Wait until every vector is sent and every result has come back, then
    // let the pipeline settle.
    task automatic drain();
        @(negedge clk);
        while (vec_pending.size() != 0 || in_valid || polar_due.size() != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Write the tolerance register; call only with the unit empty.
    task automatic set_tolerance(input int v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= TOL_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_now = TOL_W'(v);
        settings_used++;
    endtask

    // Send n random vectors in chunks, each chunk with its own idle odds so
    // some stretches run with no idling at all. Pause in the middle when asked.
    task automatic run_random(input int n, input bit pause_midway);
        int pct [4];
        int k;
        pct = '{0, 15, 40, 70};
        k = 0;
        while (k < n)
        begin
            @(negedge clk);
            while (vec_pending.size() != 0)
                @(negedge clk);
            if (pause_midway && k >= n / 2 && k < n / 2 + 50)
                drain();
            in_idle_pct  = pct[$urandom_range(0, 3)];
            out_idle_pct = pct[$urandom_range(0, 3)];
            repeat (50)
            begin
                if (k < n)
                    queue_vec(pick_component(int'(tol_now)), pick_component(int'(tol_now)));
                k++;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Tolerance at its reset value of zero: exact axes, the origin, the
        // corners of the range, the four diagonals, vectors hugging an axis,
        // and a fourth-quadrant angle that rounds up to a full turn.
        in_idle_pct  = 30;
        out_idle_pct = 30;
        queue_vec(0, 0);
        queue_vec(0, 100);
        queue_vec(0, -100);
        queue_vec(100, 0);
        queue_vec(-100, 0);
        queue_vec(32767, 32767);
        queue_vec(-32768, -32768);
        queue_vec(32767, -32768);
        queue_vec(-32768, 32767);
        queue_vec(1, 1);
        queue_vec(-1, 1);
        queue_vec(-1, -1);
        queue_vec(1, -1);
        queue_vec(30000, -3);
        queue_vec(-32768, 0);
        queue_vec(0, -32768);
        queue_vec(1, 32767);
        queue_vec(-32767, 1);
        drain();

        // Widest tolerance: snapped angles whose length still comes from the
        // true components, and both sides of the tolerance edge.
        set_tolerance(255);
        queue_vec(-200, -200);
        queue_vec(255, -255);
        queue_vec(256, 3);
        queue_vec(-3, -256);
        queue_vec(-256, 255);
        queue_vec(-32768, 255);
        drain();
        run_random(200, 1'b0);

        // Back to zero, with the sender held until the unit empties midway.
        set_tolerance(0);
        run_random(250, 1'b1);

        set_tolerance(1);
        run_random(200, 1'b0);

        set_tolerance($urandom_range(2, 254));
        run_random(300, 1'b0);

        set_tolerance(128);
        run_random(200, 1'b0);

        $display("sent %0d vectors, checked %0d results, %0d of them snapped to an axis",
                 words_sent, words_checked, axis_seen);
        $display("zero tolerance took %0d settings from 0 to 255; %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("vec2_angle_and_magnitude_unit_test: done, clean");
        else
            $display("vec2_angle_and_magnitude_unit_test: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("timeout: %0d results still outstanding", polar_due.size());
        $display("vec2_angle_and_magnitude_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vam_pkg.sv
hw/rtl/vec2_angle_and_magnitude_unit.sv
test/vec2_angle_and_magnitude_unit_test.sv
